[rtl/tds_pkg.sv]
// Package: shared constants, types and fixed-point helpers of the tridiagonal solver.
package tds_pkg;

	localparam int unsigned MaxRowsDefault  = 32;
	localparam int unsigned FracBitsDefault = 16;
	localparam int unsigned DataW           = 32;
	localparam int unsigned IdxOutW         = 5;
	localparam int unsigned StatusW         = 2;

	typedef enum logic [1:0] {
		ST_OK         = 2'd0,
		ST_ZERO_PIVOT = 2'd1,
		ST_OVERFLOW   = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [DataW-1:0] sub_diag;
		logic signed [DataW-1:0] main_diag;
		logic signed [DataW-1:0] super_diag;
		logic signed [DataW-1:0] rhs_value;
		logic                    last_row;
	} row_t;

	function automatic logic signed [DataW-1:0] sat_from65(input logic signed [64:0] v);
		logic signed [64:0] hi;
		logic signed [64:0] lo;
		hi = 65'sd2147483647;
		lo = -65'sd2147483648;
		if (v > hi) begin
			return 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			return 32'sh8000_0000;
		end
		return v[DataW-1:0];
	endfunction

	function automatic logic signed [DataW-1:0] sat_sub(
		input logic signed [DataW-1:0] x,
		input logic signed [DataW-1:0] y
	);
		logic signed [DataW:0] s;
		s = {x[DataW-1], x} - {y[DataW-1], y};
		if (s[DataW] != s[DataW-1]) begin
			return s[DataW] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
		end
		return s[DataW-1:0];
	endfunction

endpackage

[rtl/tds_ram.sv]
// Generic single-port-write, registered-read RAM.
module tds_ram #(
	parameter int unsigned Width = 32,
	parameter int unsigned Depth = 32,
	parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AddrW-1:0] waddr,
	input  logic [Width-1:0] wdata,
	input  logic [AddrW-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

[rtl/tds_front.sv]
// Front end: accepts row beats into a short queue.
module tds_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  tds_pkg::row_t in_row,
	output logic          q_valid,
	input  logic          q_ready,
	output tds_pkg::row_t q_row
);
	import tds_pkg::*;

	row_t      buf_q [2];
	logic      wp_q;
	logic      rp_q;
	logic [1:0] cnt_q;
	logic      push;
	logic      pop;

	assign in_ready = (cnt_q != 2'd2);
	assign q_valid  = (cnt_q != 2'd0);
	assign q_row    = buf_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= in_row;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

[rtl/tds_div.sv]
// Iterative restoring divider: (num << FracBits) / den, truncated, saturated.
module tds_div #(
	parameter int unsigned FracBits = tds_pkg::FracBitsDefault
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic signed [tds_pkg::DataW-1:0] num,
	input  logic signed [tds_pkg::DataW-1:0] den,
	output logic                            done,
	output logic signed [tds_pkg::DataW-1:0] quot
);
	import tds_pkg::*;

	localparam int unsigned NW   = DataW + FracBits;
	localparam int unsigned CntW = $clog2(NW + 1);

	logic [NW-1:0]   n_q;
	logic [NW-1:0]   q_q;
	logic [DataW:0]  rem_q;
	logic [DataW-1:0] d_q;
	logic            neg_q;
	logic [CntW-1:0] cnt_q;
	logic            busy_q;
	logic [DataW:0]  trial;
	logic [DataW:0]  diff;
	logic [DataW-1:0] num_mag;
	logic [DataW-1:0] den_mag;
	logic signed [64:0] sq;

	assign num_mag = num[DataW-1] ? (~num + 1'b1) : num;
	assign den_mag = den[DataW-1] ? (~den + 1'b1) : den;
	assign trial   = {rem_q[DataW-1:0], n_q[NW-1]};
	assign diff    = trial - {1'b0, d_q};

	always_comb begin
		sq = neg_q ? -$signed({{(65-NW){1'b0}}, q_q}) : $signed({{(65-NW){1'b0}}, q_q});
		quot = sat_from65(sq);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done   <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= {num_mag, {FracBits{1'b0}}};
			d_q   <= den_mag;
			neg_q <= num[DataW-1] ^ den[DataW-1];
			rem_q <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			n_q <= {n_q[NW-2:0], 1'b0};
			if (!diff[DataW]) begin
				rem_q <= diff;
				q_q   <= {q_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				q_q   <= {q_q[NW-2:0], 1'b0};
			end
		end
	end
endmodule

[rtl/tds_back.sv]
// Back end: forward sweep per row, then back substitution on the last row.
module tds_back #(
	parameter int unsigned MaxRows  = tds_pkg::MaxRowsDefault,
	parameter int unsigned FracBits = tds_pkg::FracBitsDefault
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	output logic                             q_ready,
	input  tds_pkg::row_t                    q_row,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic signed [tds_pkg::DataW-1:0] out_solution,
	output logic [tds_pkg::IdxOutW-1:0]      out_index,
	output logic [tds_pkg::StatusW-1:0]      out_status,
	output logic                             out_last
);
	import tds_pkg::*;

	localparam int unsigned AW = (MaxRows > 1) ? $clog2(MaxRows) : 1;
	localparam int unsigned CW = $clog2(MaxRows + 1);

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_RD    = 12'b000000000010,
		S_MUL   = 12'b000000000100,
		S_SUB   = 12'b000000001000,
		S_CHK   = 12'b000000010000,
		S_DIVH  = 12'b000000100000,
		S_DIVP  = 12'b000001000000,
		S_WR    = 12'b000010000000,
		S_BRD   = 12'b000100000000,
		S_BMUL  = 12'b001000000000,
		S_BSUB  = 12'b010000000000,
		S_BOUT  = 12'b100000000000
	} state_t;

	state_t state_q;
	row_t   row_q;
	logic [CW-1:0] cnt_q;
	status_t err_q;
	logic [AW-1:0] bi_q;
	logic signed [DataW-1:0] d_q, p_q, h_q, x_q;
	logic signed [63:0] prod_h_q, prod_p_q;
	logic                   first_q;

	logic                    ram_we;
	logic [AW-1:0]           ram_waddr, ram_raddr;
	logic signed [DataW-1:0] h_rd, p_rd;

	logic                    div_start, div_done;
	logic signed [DataW-1:0] div_num, div_quot;

	function automatic logic signed [DataW-1:0] fx_shift(input logic signed [63:0] p);
		return sat_from65(65'(p >>> FracBits));
	endfunction

	tds_ram #(.Width(DataW), .Depth(MaxRows)) u_h (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(h_q),
		.raddr(ram_raddr), .rdata(h_rd)
	);
	tds_ram #(.Width(DataW), .Depth(MaxRows)) u_p (
		.clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(p_q),
		.raddr(ram_raddr), .rdata(p_rd)
	);
	tds_div #(.FracBits(FracBits)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .num(div_num), .den(d_q),
		.done(div_done), .quot(div_quot)
	);

	assign q_ready   = (state_q == S_IDLE);
	assign ram_we    = (state_q == S_WR);
	assign ram_waddr = cnt_q[AW-1:0];
	assign ram_raddr = (state_q == S_RD) ? AW'(cnt_q - 1'b1) : bi_q;
	assign div_start = ((state_q == S_CHK) && (d_q != '0)) ||
	                   ((state_q == S_DIVH) && div_done);
	assign div_num   = (state_q == S_CHK) ? (row_q.last_row ? '0 : row_q.super_diag) : p_q;
	assign out_valid = (state_q == S_BOUT);
	assign out_solution = x_q;
	assign out_index    = IdxOutW'(bi_q);
	assign out_status   = err_q;
	assign out_last     = (bi_q == '0);

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				row_q <= q_row;
				d_q   <= q_row.main_diag;
				p_q   <= q_row.rhs_value;
			end
			S_MUL: begin
				prod_h_q <= 64'(row_q.sub_diag) * 64'(h_rd);
				prod_p_q <= 64'(row_q.sub_diag) * 64'(p_rd);
			end
			S_SUB: begin
				d_q <= sat_sub(row_q.main_diag, fx_shift(prod_h_q));
				p_q <= sat_sub(row_q.rhs_value, fx_shift(prod_p_q));
			end
			S_CHK: if (d_q == '0) begin
				h_q <= '0;
				p_q <= '0;
			end
			S_DIVH: if (div_done) h_q <= div_quot;
			S_DIVP: if (div_done) p_q <= div_quot;
			S_BMUL: prod_h_q <= 64'(h_rd) * 64'(x_q);
			S_BSUB: x_q <= first_q ? p_rd : sat_sub(p_rd, fx_shift(prod_h_q));
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			err_q   <= ST_OK;
			bi_q    <= '0;
			first_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (q_valid) begin
					if (cnt_q >= CW'(MaxRows)) begin
						if (err_q == ST_OK) err_q <= ST_OVERFLOW;
						if (q_row.last_row) begin
							bi_q    <= AW'(cnt_q - 1'b1);
							first_q <= 1'b1;
							state_q <= S_BRD;
						end
					end else begin
						state_q <= (cnt_q == '0) ? S_CHK : S_RD;
					end
				end
				S_RD:  state_q <= S_MUL;
				S_MUL: state_q <= S_SUB;
				S_SUB: state_q <= S_CHK;
				S_CHK: begin
					if (d_q == '0) begin
						if (err_q == ST_OK) err_q <= ST_ZERO_PIVOT;
						state_q <= S_WR;
					end else begin
						state_q <= S_DIVH;
					end
				end
				S_DIVH: if (div_done) state_q <= S_DIVP;
				S_DIVP: if (div_done) state_q <= S_WR;
				S_WR: begin
					cnt_q <= cnt_q + 1'b1;
					if (row_q.last_row) begin
						bi_q    <= cnt_q[AW-1:0];
						first_q <= 1'b1;
						state_q <= S_BRD;
					end else begin
						state_q <= S_IDLE;
					end
				end
				S_BRD:  state_q <= S_BMUL;
				S_BMUL: state_q <= S_BSUB;
				S_BSUB: state_q <= S_BOUT;
				S_BOUT: if (out_ready) begin
					first_q <= 1'b0;
					if (bi_q == '0) begin
						cnt_q   <= '0;
						err_q   <= ST_OK;
						state_q <= S_IDLE;
					end else begin
						bi_q    <= bi_q - 1'b1;
						state_q <= S_BRD;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

[rtl/tridiagonal_system_solver.sv]
// Top level: tridiagonal system solver, Thomas algorithm in signed fixed point.
// Rows enter one per beat; each row's processing time is set by two quotients
// through one bit-per-cycle divider. After the last row the solutions leave
// from the highest index down to 0, each result passing through the store read
// and multiplier. Rows beyond MAX_ROWS are dropped with status 2; a zero pivot
// gives status 1. A two-deep queue decouples input.
module tridiagonal_system_solver #(
	parameter int unsigned MAX_ROWS  = tds_pkg::MaxRowsDefault,
	parameter int unsigned FRAC_BITS = tds_pkg::FracBitsDefault
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // sub_diag, main_diag, super_diag, rhs_value
	input  logic         s_axis_tlast,  // last_row
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [39:0]  m_axis_tdata,  // solution, row_index, status, zero fill
	output logic         m_axis_tlast   // last_out
);
	import tds_pkg::*;

	row_t in_row, q_row;
	logic q_valid, q_ready;
	logic signed [DataW-1:0] sol;
	logic [IdxOutW-1:0] idx;
	logic [StatusW-1:0] st;

	assign in_row.sub_diag   = s_axis_tdata[31:0];
	assign in_row.main_diag  = s_axis_tdata[63:32];
	assign in_row.super_diag = s_axis_tdata[95:64];
	assign in_row.rhs_value  = s_axis_tdata[127:96];
	assign in_row.last_row   = s_axis_tlast;
	assign m_axis_tdata      = {1'b0, st, idx, sol};

	tds_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_row(in_row), .q_valid(q_valid), .q_ready(q_ready), .q_row(q_row)
	);

	tds_back #(.MaxRows(MAX_ROWS), .FracBits(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .q_valid(q_valid), .q_ready(q_ready), .q_row(q_row),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_solution(sol),
		.out_index(idx), .out_status(st), .out_last(m_axis_tlast)
	);
endmodule

[rtl/tds_checker.sv]
// Port checker for the tridiagonal solver, bound to the top level.
module tds_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [39:0]  m_axis_tdata,
	input logic         m_axis_tlast
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");
	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[38:37] != 2'd3)
		else $error("bad status code");
	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[36:32] == 5'd0)
		else $error("last beat not index 0");
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[39] == 1'b0)
		else $error("fill bit set");
	a_in_known: assert property (@(posedge clk) disable iff (!arst_n)
		!$isunknown({s_axis_tvalid, s_axis_tready}))
		else $error("input handshake unknown");
endmodule

bind tridiagonal_system_solver tds_checker u_tds_checker (
	.clk(clk), .arst_n(arst_n), .s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready), .m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
	.m_axis_tlast(m_axis_tlast)
);
